@@ hw/rtl/spd_pkg.sv @@
package spd_pkg;

   localparam int PAYLOAD_BYTES = 32;
   localparam int CHAN_BASE     = 2;
   localparam int SLOT_CHANNELS = 8;
   localparam int ACCEL_BASE    = CHAN_BASE + 3 * SLOT_CHANNELS;
   localparam int NUM_AXES      = 3;
   localparam int NUM_VALUES    = SLOT_CHANNELS + NUM_AXES;

   localparam logic [1:0] CSR_START_MARKER  = 2'd0;
   localparam logic [1:0] CSR_END_MARKER    = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_SCALE = 2'd2;
   localparam logic [1:0] CSR_MOTION_SCALE  = 2'd3;

   localparam logic [7:0]  START_MARKER_RESET  = 8'hA0;
   localparam logic [7:0]  END_MARKER_RESET    = 8'hC0;
   localparam logic [31:0] CHANNEL_SCALE_RESET = 32'd375000;
   localparam logic [31:0] MOTION_SCALE_RESET  = 32'd2097;

   typedef logic [5:0] pos_type;
   typedef logic [3:0] slot_type;

   // one completed field or the end of a packet, from the parser to the scaler
   typedef struct packed {
      logic        load;
      logic        is_accel;
      slot_type    slot;
      logic [23:0] operand;
      logic        finish;
   } field_event_type;

endpackage

@@ hw/rtl/spd_parser.sv @@
module spd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   input  logic [7:0]              start_marker,
   input  logic [7:0]              end_marker,
   output spd_pkg::field_event_type field_evt,
   output logic [7:0]              sample_number
);

   spd_pkg::pos_type  pos_ff, pos_in;
   logic [1:0]        phase_ff, phase_in;
   spd_pkg::slot_type slot_ff, slot_in;
   logic [15:0]       acc_ff, acc_in;
   logic [7:0]        sample_ff, sample_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= '0;
         slot_ff   <= '0;
         acc_ff    <= '0;
         sample_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         acc_ff    <= acc_in;
         sample_ff <= sample_in;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      slot_in   = slot_ff;
      acc_in    = acc_ff;
      sample_in = sample_ff;
      field_evt = '0;
      if (accept) begin
         if (pos_ff == '0) begin
            // hunting
            if (rx_byte == start_marker) begin
               pos_in = 6'd1;
               acc_in = '0;
            end
         end else if (pos_ff == 6'd1) begin
            sample_in = rx_byte;
            acc_in    = '0;
            phase_in  = '0;
            slot_in   = '0;
            pos_in    = pos_ff + 6'd1;
         end else if (pos_ff < 6'(spd_pkg::ACCEL_BASE)) begin
            acc_in = {acc_ff[7:0], rx_byte};
            pos_in = pos_ff + 6'd1;
            if (phase_ff == 2'd2) begin
               field_evt.load     = 1'b1;
               field_evt.is_accel = 1'b0;
               field_evt.slot     = slot_ff;
               field_evt.operand  = {acc_ff, rx_byte};
               acc_in             = '0;
               phase_in           = '0;
               slot_in            = slot_ff + 4'd1;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end else if (pos_ff < 6'(spd_pkg::PAYLOAD_BYTES)) begin
            acc_in = {acc_ff[7:0], rx_byte};
            pos_in = pos_ff + 6'd1;
            if (phase_ff == 2'd1) begin
               field_evt.load     = 1'b1;
               field_evt.is_accel = 1'b1;
               field_evt.slot     = slot_ff;
               field_evt.operand  = {{8{acc_ff[7]}}, acc_ff[7:0], rx_byte};
               acc_in             = '0;
               phase_in           = '0;
               slot_in            = slot_ff + 4'd1;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end else begin
            // end byte: a mismatch just drops the packet
            pos_in           = '0;
            acc_in           = '0;
            field_evt.finish = (rx_byte == end_marker);
         end
      end
   end

   assign sample_number = sample_ff;

endmodule

@@ hw/rtl/sensor_packet_deframer.sv @@
// a finished packet passes through finish_ff into the result register after its end byte transfer
// throughput: one byte per cycle when not stalled; one result per 33-byte packet at most
// the input stalls only while a finished packet waits behind a stalled result
// reset: synchronous, restores marker and scale defaults and resumes the start hunt
// each field is scaled by one 24x33 multiplier in the cycle after its last byte
module sensor_packet_deframer #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_sample_number,
   output logic signed [55:0] rsp_chan1_value,
   output logic signed [55:0] rsp_chan2_value,
   output logic signed [55:0] rsp_chan3_value,
   output logic signed [55:0] rsp_chan4_value,
   output logic signed [55:0] rsp_chan5_value,
   output logic signed [55:0] rsp_chan6_value,
   output logic signed [55:0] rsp_chan7_value,
   output logic signed [55:0] rsp_chan8_value,
   output logic signed [47:0] rsp_accel_x,
   output logic signed [47:0] rsp_accel_y,
   output logic signed [47:0] rsp_accel_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int NV = spd_pkg::NUM_VALUES;

   logic [7:0]  start_marker_ff, end_marker_ff;
   logic [31:0] channel_scale_ff, motion_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= spd_pkg::START_MARKER_RESET;
         end_marker_ff    <= spd_pkg::END_MARKER_RESET;
         channel_scale_ff <= spd_pkg::CHANNEL_SCALE_RESET;
         motion_scale_ff  <= spd_pkg::MOTION_SCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            spd_pkg::CSR_START_MARKER:  start_marker_ff  <= csr_wdata[7:0];
            spd_pkg::CSR_END_MARKER:    end_marker_ff    <= csr_wdata[7:0];
            spd_pkg::CSR_CHANNEL_SCALE: channel_scale_ff <= csr_wdata;
            spd_pkg::CSR_MOTION_SCALE:  motion_scale_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                     accept;
   logic                     out_free;
   spd_pkg::field_event_type field_evt;
   logic [7:0]               sample_number;

   assign accept = req_valid && !req_stall;

   spd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_rx_byte),
      .start_marker  (start_marker_ff),
      .end_marker    (end_marker_ff),
      .field_evt     (field_evt),
      .sample_number (sample_number)
   );

   // scaling stage
   spd_pkg::field_event_type mul_ff;
   logic finish_ff, finish_in;
   logic [31:0]        gain;
   logic signed [56:0] product;
   logic               zero_fill;
   logic [55:0]        held_ff [NV];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff    <= '0;
         finish_ff <= 1'b0;
      end else begin
         mul_ff    <= field_evt;
         finish_ff <= finish_in;
      end
   end

   always_comb begin
      gain      = mul_ff.is_accel ? motion_scale_ff : channel_scale_ff;
      product   = $signed(mul_ff.operand) * $signed({1'b0, gain});
      zero_fill = !mul_ff.is_accel && (mul_ff.slot >= 4'(NUM_CHANNELS));
   end

   always_ff @(posedge clock) begin
      if (mul_ff.load) begin
         held_ff[mul_ff.slot] <= zero_fill ? '0 : product[55:0];
      end
   end

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_sample_ff;
   logic [55:0] out_value_ff [NV];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = finish_ff && !out_free;

   always_comb begin
      finish_in    = field_evt.finish || (finish_ff && !out_free);
      rsp_valid_in = (finish_ff && out_free) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_ff && out_free) begin
         out_sample_ff <= sample_number;
         for (int i = 0; i < NV; i++) begin
            out_value_ff[i] <= held_ff[i];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_number = out_sample_ff;
   assign rsp_chan1_value   = $signed(out_value_ff[0]);
   assign rsp_chan2_value   = $signed(out_value_ff[1]);
   assign rsp_chan3_value   = $signed(out_value_ff[2]);
   assign rsp_chan4_value   = $signed(out_value_ff[3]);
   assign rsp_chan5_value   = $signed(out_value_ff[4]);
   assign rsp_chan6_value   = $signed(out_value_ff[5]);
   assign rsp_chan7_value   = $signed(out_value_ff[6]);
   assign rsp_chan8_value   = $signed(out_value_ff[7]);
   assign rsp_accel_x       = $signed(out_value_ff[8][47:0]);
   assign rsp_accel_y       = $signed(out_value_ff[9][47:0]);
   assign rsp_accel_z       = $signed(out_value_ff[10][47:0]);

   // the last field is written before the packet is copied out
   a_no_write_during_copy: assert property (@(posedge clock) disable iff (reset)
      !(mul_ff.load && finish_ff))
      else $error("field write collides with result copy");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish_ff))
      else $error("result appeared without a finished packet");

   a_finish_drains: assert property (@(posedge clock) disable iff (reset)
      finish_ff && out_free |=> rsp_valid_ff && !finish_ff)
      else $error("finished packet not moved to result register");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> finish_ff && rsp_valid_ff)
      else $error("input stalled with no blocked packet");

endmodule

@@ tb/sensor_packet_deframer_tb.sv @@
module sensor_packet_deframer_tb;

   localparam int NUM_CHANNELS = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_ITEMS  = 300;

   typedef struct packed {
      logic [7:0]       sample_number;
      logic [7:0][55:0] chan;
      logic [2:0][47:0] accel;
   } frame_fields_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [7:0]         rsp_sample_number;
   logic signed [55:0] rsp_chan1_value;
   logic signed [55:0] rsp_chan2_value;
   logic signed [55:0] rsp_chan3_value;
   logic signed [55:0] rsp_chan4_value;
   logic signed [55:0] rsp_chan5_value;
   logic signed [55:0] rsp_chan6_value;
   logic signed [55:0] rsp_chan7_value;
   logic signed [55:0] rsp_chan8_value;
   logic signed [47:0] rsp_accel_x;
   logic signed [47:0] rsp_accel_y;
   logic signed [47:0] rsp_accel_z;
   logic               csr_write   = 1'b0;
   logic [1:0]         csr_index   = 2'd0;
   logic [31:0]        csr_wdata   = 32'd0;

   // deframer state mirrored by the predictor
   logic [7:0]       cfg_start;
   logic [7:0]       cfg_end;
   logic [31:0]      cfg_chan_gain;
   logic [31:0]      cfg_motion_gain;
   spd_pkg::pos_type frame_pos;
   logic [23:0]      field_acc;
   logic [7:0]       held_sample;
   logic [55:0]      held_vals [spd_pkg::NUM_VALUES];

   frame_fields_type pending_frames[$];
   int            mismatches  = 0;
   int            items_sent  = 0;
   int            cycle_count = 0;
   int            stall_left  = 0;
   bit            idle_on     = 1'b1;

   sensor_packet_deframer #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_number(rsp_sample_number),
      .rsp_chan1_value(rsp_chan1_value),
      .rsp_chan2_value(rsp_chan2_value),
      .rsp_chan3_value(rsp_chan3_value),
      .rsp_chan4_value(rsp_chan4_value),
      .rsp_chan5_value(rsp_chan5_value),
      .rsp_chan6_value(rsp_chan6_value),
      .rsp_chan7_value(rsp_chan7_value),
      .rsp_chan8_value(rsp_chan8_value),
      .rsp_accel_x(rsp_accel_x),
      .rsp_accel_y(rsp_accel_y),
      .rsp_accel_z(rsp_accel_z),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sensor_packet_deframer: mismatch");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [55:0] scale_chan(input logic [23:0] raw, input logic [31:0] gain);
      logic signed [23:0] sraw;
      longint             v;
      longint             g;
      longint             p;
      sraw = raw;
      v    = sraw;
      g    = gain;
      p    = v * g;
      return p[55:0];
   endfunction

   function automatic logic [47:0] scale_axis(input logic [15:0] raw, input logic [31:0] gain);
      logic signed [15:0] sraw;
      longint             v;
      longint             g;
      longint             p;
      sraw = raw;
      v    = sraw;
      g    = gain;
      p    = v * g;
      return p[47:0];
   endfunction

   task automatic model_reset();
      cfg_start       = spd_pkg::START_MARKER_RESET;
      cfg_end         = spd_pkg::END_MARKER_RESET;
      cfg_chan_gain   = spd_pkg::CHANNEL_SCALE_RESET;
      cfg_motion_gain = spd_pkg::MOTION_SCALE_RESET;
      frame_pos       = '0;
      field_acc       = '0;
      held_sample     = '0;
      for (int i = 0; i < spd_pkg::NUM_VALUES; i++) held_vals[i] = '0;
   endtask

   // advances the mirrored parser by one byte, returns 1 when a frame completes
   function automatic bit deframe_byte(input logic [7:0] b, output frame_fields_type res);
      int rel;
      res = '0;
      if (frame_pos == 0) begin
         if (b == cfg_start) begin
            frame_pos = 6'd1;
            field_acc = '0;
         end
         return 1'b0;
      end
      if (frame_pos == 1) begin
         held_sample = b;
         field_acc   = '0;
      end else if (frame_pos < spd_pkg::ACCEL_BASE) begin
         rel       = int'(frame_pos) - spd_pkg::CHAN_BASE;
         field_acc = {field_acc[15:0], b};
         if (rel % 3 == 2) begin
            held_vals[rel / 3] = (rel / 3 < NUM_CHANNELS) ?
                                 scale_chan(field_acc, cfg_chan_gain) : 56'd0;
            field_acc = '0;
         end
      end else if (frame_pos < spd_pkg::PAYLOAD_BYTES) begin
         rel       = int'(frame_pos) - spd_pkg::ACCEL_BASE;
         field_acc = {field_acc[15:0], b};
         if (rel % 2 == 1) begin
            held_vals[spd_pkg::SLOT_CHANNELS + rel / 2] =
               {8'd0, scale_axis(field_acc[15:0], cfg_motion_gain)};
            field_acc = '0;
         end
      end else begin
         // end byte: the hunt restarts with the next byte either way
         frame_pos = '0;
         field_acc = '0;
         if (b != cfg_end) return 1'b0;
         res.sample_number = held_sample;
         for (int i = 0; i < spd_pkg::SLOT_CHANNELS; i++) res.chan[i] = held_vals[i];
         for (int i = 0; i < spd_pkg::NUM_AXES; i++)
            res.accel[i] = held_vals[spd_pkg::SLOT_CHANNELS + i][47:0];
         return 1'b1;
      end
      frame_pos = frame_pos + 6'd1;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t %s: got %h, expected %h", $time, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      frame_fields_type got;
      frame_fields_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_sample_number,
                rsp_chan8_value, rsp_chan7_value, rsp_chan6_value, rsp_chan5_value,
                rsp_chan4_value, rsp_chan3_value, rsp_chan2_value, rsp_chan1_value,
                rsp_accel_z, rsp_accel_y, rsp_accel_x};
         if (pending_frames.size() == 0) begin
            report_mismatch("unexpected result", 64'd0, 64'd0);
         end else begin
            want = pending_frames.pop_front();
            if (got.sample_number !== want.sample_number)
               report_mismatch("sample_number", 64'(got.sample_number),
                               64'(want.sample_number));
            for (int i = 0; i < spd_pkg::SLOT_CHANNELS; i++)
               if (got.chan[i] !== want.chan[i])
                  report_mismatch($sformatf("chan%0d_value", i + 1), 64'(got.chan[i]),
                                  64'(want.chan[i]));
            for (int i = 0; i < spd_pkg::NUM_AXES; i++)
               if (got.accel[i] !== want.accel[i])
                  report_mismatch($sformatf("accel axis %0d", i), 64'(got.accel[i]),
                                  64'(want.accel[i]));
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      frame_fields_type res;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (deframe_byte(b, res)) pending_frames.push_back(res);
      items_sent++;
   endtask

   task automatic send_frame(input logic [7:0] smp, input logic [7:0][23:0] ch,
                             input logic [2:0][15:0] ax, input logic [7:0] tail);
      send_byte(cfg_start);
      send_byte(smp);
      for (int i = 0; i < spd_pkg::SLOT_CHANNELS; i++) begin
         send_byte(ch[i][23:16]);
         send_byte(ch[i][15:8]);
         send_byte(ch[i][7:0]);
      end
      for (int i = 0; i < spd_pkg::NUM_AXES; i++) begin
         send_byte(ax[i][15:8]);
         send_byte(ax[i][7:0]);
      end
      send_byte(tail);
   endtask

   function automatic logic [23:0] pick_chan();
      case ($urandom_range(0, 9))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         3:       return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_marker();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 32'h00000000;
         1:       return 32'hFFFFFFFF;
         2:       return 32'h01000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_frame(input bit good_end);
      logic [7:0][23:0] ch;
      logic [2:0][15:0] ax;
      logic [7:0]       tail;
      for (int i = 0; i < spd_pkg::SLOT_CHANNELS; i++) ch[i] = pick_chan();
      for (int i = 0; i < spd_pkg::NUM_AXES; i++) ax[i] = pick_axis();
      tail = cfg_end;
      if (!good_end) begin
         // a bad end byte equal to the start marker must not open a new packet
         if (cfg_start != cfg_end && $urandom_range(0, 1) == 0)
            tail = cfg_start;
         else
            tail = cfg_end ^ 8'($urandom_range(1, 255));
      end
      send_frame(8'($urandom), ch, ax, tail);
   endtask

   task automatic send_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         b = 8'($urandom);
         if (b == cfg_start) b = ~b;
         send_byte(b);
      end
   endtask

   task automatic send_truncated();
      send_byte(cfg_start);
      repeat ($urandom_range(1, 31)) send_byte(8'($urandom));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_one(input logic [1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         spd_pkg::CSR_START_MARKER:  cfg_start       = data[7:0];
         spd_pkg::CSR_END_MARKER:    cfg_end         = data[7:0];
         spd_pkg::CSR_CHANNEL_SCALE: cfg_chan_gain   = data;
         spd_pkg::CSR_MOTION_SCALE:  cfg_motion_gain = data;
      endcase
   endtask

   // upper bits of the marker writes carry junk that must be dropped
   task automatic write_regs(input logic [7:0] sm, input logic [7:0] em,
                             input logic [31:0] cs, input logic [31:0] ms);
      write_one(spd_pkg::CSR_START_MARKER, {24'($urandom), sm});
      write_one(spd_pkg::CSR_END_MARKER, {24'($urandom), em});
      write_one(spd_pkg::CSR_CHANNEL_SCALE, cs);
      write_one(spd_pkg::CSR_MOTION_SCALE, ms);
      csr_write <= 1'b0;
   endtask

   task automatic test_extreme_fields();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'hFF,
                 {24'h000000, 24'h000001, 24'h800000, 24'h7FFFFF,
                  24'hFFFFFF, 24'h000000, 24'h800000, 24'h7FFFFF},
                 {16'hFFFF, 16'h8000, 16'h7FFF}, cfg_end);
      send_frame(8'h00,
                 {24'hFFFFFF, 24'hFFFFFE, 24'h7FFFFF, 24'h800000,
                  24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000},
                 {16'h0000, 16'h7FFF, 16'h8000}, cfg_end);
   endtask

   task automatic test_end_mismatch();
      logic [7:0][23:0] marker_ch;
      for (int i = 0; i < spd_pkg::SLOT_CHANNELS; i++) marker_ch[i] = {3{cfg_start}};
      send_frame(8'h11, marker_ch, {16'h1234, 16'h5678, 16'h9ABC}, cfg_start);
      // start marker bytes inside the payload are plain data
      send_frame(cfg_start, marker_ch, {3{cfg_start, cfg_start}}, cfg_end);
      send_frame(8'h22, marker_ch, {16'h0001, 16'hFFFE, 16'h8001}, cfg_end ^ 8'h01);
      send_random_frame(1'b1);
   endtask

   task automatic test_register_extremes();
      wait_for_results();
      write_regs(8'h00, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      test_extreme_fields();
      send_random_frame(1'b1);
      wait_for_results();
      write_regs(8'hFF, 8'h00, 32'h00000000, 32'h00000000);
      send_random_frame(1'b1);
      send_random_frame(1'b0);
      send_random_frame(1'b1);
      wait_for_results();
      // start and end share a value
      write_regs(8'h5A, 8'h5A, 32'h01000000, 32'h01000000);
      send_random_frame(1'b1);
      send_noise(3);
      send_random_frame(1'b1);
   endtask

   task automatic test_random_traffic();
      int target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (items_sent > target - QUIET_ITEMS) idle_on = 1'b0;
         wait_for_results();
         write_regs(pick_marker(), pick_marker(), pick_gain(), pick_gain());
         repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 19))
               0, 1:    send_random_frame(1'b0);
               2:       send_noise($urandom_range(1, 6));
               3:       send_truncated();
               default: send_random_frame(1'b1);
            endcase
         end
      end
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_extreme_fields();
      test_end_mismatch();
      test_register_extremes();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("sensor_packet_deframer: match");
      else
         $display("sensor_packet_deframer: mismatch");
      $finish;
   end

endmodule
